### hdl/knob_angle_to_scroll_ticks_defines.svh
// Assertion macros shared by the knob angle to scroll ticks RTL
`ifndef KNOB_ANGLE_TO_SCROLL_TICKS_DEFINES_SVH
`define KNOB_ANGLE_TO_SCROLL_TICKS_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define KATS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kats: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define KATS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kats: next-cycle check failed");

`endif

### hdl/kats_pkg.sv
// Shared types and constants for the knob angle to scroll ticks block
`default_nettype none

package kats_pkg;

   // Fixed point
   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int CNT_W     = $clog2(FRAC_BITS);
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

   // Multiplier second operand, acceleration factor width
   localparam int ACCEL_W = 20;

   // Shared compare/subtract unit and step count divide
   localparam int DIV_W = 36;
   localparam int NQ_W  = 5;

   // Idle decay: 0.85 in Q16
   localparam logic [16:0] DECAY_MUL   = 17'd55706;
   localparam int          DECAY_SHIFT = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THRESH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_CPS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_CPS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_SPEED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCEL   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TMO    = 3'd6;

   localparam logic [7:0]  RST_DEAD_ZONE   = 8'd2;
   localparam logic [19:0] RST_STOP_THRESH = 20'd78643;
   localparam logic [15:0] RST_BASE_CPS    = 16'd700;
   localparam logic [15:0] RST_FAST_CPS    = 16'd220;
   localparam logic [11:0] RST_FAST_SPEED  = 12'd8;
   localparam logic [18:0] RST_MAX_ACCEL   = 19'd131072;
   localparam logic [15:0] RST_IDLE_TMO    = 16'd1500;

   // Run modes
   localparam logic [1:0] MODE_ADV    = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_IDLE   = 2'd2;

   // Poll delays in milliseconds
   localparam logic [6:0] POLL_ADV  = 7'd80;
   localparam logic [6:0] POLL_IDLE = 7'd25;
   localparam logic [6:0] POLL_SLOW = 7'd8;
   localparam logic [6:0] POLL_FAST = 7'd2;

   // Result of one compare/subtract step
   typedef struct packed {
      logic             ge;
      logic [DIV_W-1:0] diff;
   } div_res_type;

endpackage

`default_nettype wire

### hdl/knob_angle_to_scroll_ticks.sv
// Top level: knob angle samples in, scroll wheel steps out
//
//  Channel  Handshake            Payload
//  -------  -------------------  -------------------------------------------
//  req      req_valid/req_ready  req_connected, req_angle, req_now_ms
//  rsp      rsp_valid/rsp_ready  rsp_wheel_steps, rsp_mode, rsp_poll_delay_ms
//  csr      csr_write_en         csr_index, csr_wdata (write only)
//
// A disconnected sample goes from the delta state straight to output, an idle
// one is filtered and decayed, and for an active one the speed divide runs
// 16 steps on the shared compare/subtract unit unless the speed saturates,
// then the step count divide runs 5, and three products share one multiplier.
// Synchronous reset restores the control, mode and configuration registers.
// A result waits in the output register while the next sample is worked on;
// the sequencer holds before writing it until that register is free.
`default_nettype none

`include "knob_angle_to_scroll_ticks_defines.svh"

module knob_angle_to_scroll_ticks #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_connected,
   input  logic [ANGLE_BITS-1:0]               req_angle,
   input  logic [31:0]                         req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [5:0]                   rsp_wheel_steps,
   output logic [1:0]                          rsp_mode,
   output logic [6:0]                          rsp_poll_delay_ms,
   input  logic                                csr_write_en,
   input  logic [kats_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kats_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FB    = kats_pkg::FRAC_BITS;
   localparam int SW    = ANGLE_BITS + FB + 1;
   localparam int MW    = ANGLE_BITS + FB;
   localparam int DW    = ANGLE_BITS + 2;
   localparam int FW    = SW + 2;
   localparam int BW    = kats_pkg::ACCEL_W;
   localparam int PW    = SW + BW;
   localparam int IW    = PW - FB;
   localparam int SUMW  = ((IW > 32) ? IW : 32) + 1;
   localparam int DVW   = kats_pkg::DIV_W;
   localparam int NQW   = kats_pkg::NQ_W;
   localparam int CW    = kats_pkg::CNT_W;
   localparam int TW    = kats_pkg::T_W;

   localparam logic signed [DW-1:0] HALF_ANG = DW'(2 ** (ANGLE_BITS - 1));
   localparam logic signed [DW-1:0] FULL_ANG = DW'(2 ** ANGLE_BITS);

   // Sequencer states
   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DELTA  = 5'd1;
   localparam logic [4:0] ST_FILT   = 5'd2;
   localparam logic [4:0] ST_MAG    = 5'd3;
   localparam logic [4:0] ST_MODE   = 5'd4;
   localparam logic [4:0] ST_TSAT   = 5'd5;
   localparam logic [4:0] ST_TDIV   = 5'd6;
   localparam logic [4:0] ST_MULA   = 5'd7;
   localparam logic [4:0] ST_MULC   = 5'd8;
   localparam logic [4:0] ST_MULI   = 5'd9;
   localparam logic [4:0] ST_ACC    = 5'd10;
   localparam logic [4:0] ST_ABS    = 5'd11;
   localparam logic [4:0] ST_NDIV   = 5'd12;
   localparam logic [4:0] ST_FIN    = 5'd13;
   localparam logic [4:0] ST_DECAY  = 5'd14;
   localparam logic [4:0] ST_DECAYW = 5'd15;
   localparam logic [4:0] ST_OUT    = 5'd16;

   // Configuration registers
   logic [7:0]  dead_zone_ff,   dead_zone_in;
   logic [19:0] stop_thresh_ff, stop_thresh_in;
   logic [15:0] base_cps_ff,    base_cps_in;
   logic [15:0] fast_cps_ff,    fast_cps_in;
   logic [11:0] fast_speed_ff,  fast_speed_in;
   logic [18:0] max_accel_ff,   max_accel_in;
   logic [15:0] idle_tmo_ff,    idle_tmo_in;

   // Control and mode state
   logic [4:0]             state_ff,       state_in;
   logic [CW-1:0]          cnt_ff,         cnt_in;
   logic [1:0]             mode_ff,        mode_in;
   logic [ANGLE_BITS-1:0]  last_angle_ff,  last_angle_in;
   logic                   last_valid_ff,  last_valid_in;
   logic signed [SW-1:0]   smooth_ff,      smooth_in;
   logic signed [31:0]     accum_ff,       accum_in;
   logic [31:0]            last_motion_ff, last_motion_in;
   logic                   rsp_valid_ff,   rsp_valid_in;

   // Working registers
   logic                   in_conn_ff,     in_conn_in;
   logic [ANGLE_BITS-1:0]  in_angle_ff,    in_angle_in;
   logic [31:0]            in_now_ff,      in_now_in;
   logic signed [ANGLE_BITS:0] delta_ff,   delta_in;
   logic [MW-1:0]          mag_ff,         mag_in;
   logic [TW-1:0]          t_ff,           t_in;
   logic [DVW-1:0]         rem_ff,         rem_in;
   logic [DVW-1:0]         dvs_ff,         dvs_in;
   logic                   fast_ff,        fast_in;
   logic signed [BW-1:0]   accel_ff,       accel_in;
   logic [31:0]            cps_ff,         cps_in;
   logic signed [31:0]     acc_ff,         acc_in;
   logic                   acc_neg_ff,     acc_neg_in;
   logic [NQW-1:0]         nq_ff,          nq_in;
   logic signed [5:0]      res_steps_ff,   res_steps_in;
   logic [6:0]             res_poll_ff,    res_poll_in;
   logic signed [5:0]      rsp_steps_ff,   rsp_steps_in;
   logic [1:0]             rsp_mode_ff,    rsp_mode_in;
   logic [6:0]             rsp_poll_ff,    rsp_poll_in;

   // Datapath intermediates
   logic signed [DW-1:0]   d_raw, d_wrap, d_abs;
   logic                   d_dead;
   logic signed [FW-1:0]   filt_d, filt_s, filt_sum;
   logic [31:0]            since_ms;
   logic                   moving, timed_out;
   logic [1:0]             mode_nx;
   logic                   mode_touch;
   logic signed [PW-1:0]   cps_wide;
   logic signed [SUMW-1:0] acc_sum;
   logic                   acc_fits;
   logic [31:0]            acc_abs;
   logic [31:0]            left32;
   logic [MW-1:0]          decay_m;
   logic                   out_load;

   // Shared units
   logic signed [SW-1:0]   mul_a;
   logic signed [BW-1:0]   mul_b;
   logic signed [PW-1:0]   mul_prod;
   kats_pkg::div_res_type  div_res;

   kats_mul #(
      .A_W (SW),
      .B_W (BW)
   ) u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   kats_div_step u_div_step (
      .step_rem (rem_ff),
      .step_dvs (dvs_ff),
      .step_res (div_res)
   );

   // Decode configuration writes
   always_comb begin
      dead_zone_in   = dead_zone_ff;
      stop_thresh_in = stop_thresh_ff;
      base_cps_in    = base_cps_ff;
      fast_cps_in    = fast_cps_ff;
      fast_speed_in  = fast_speed_ff;
      max_accel_in   = max_accel_ff;
      idle_tmo_in    = idle_tmo_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            kats_pkg::CSR_DEAD_ZONE:   dead_zone_in   = csr_wdata[7:0];
            kats_pkg::CSR_STOP_THRESH: stop_thresh_in = csr_wdata[19:0];
            kats_pkg::CSR_BASE_CPS:    base_cps_in    = csr_wdata[15:0];
            kats_pkg::CSR_FAST_CPS:    fast_cps_in    = csr_wdata[15:0];
            kats_pkg::CSR_FAST_SPEED:  fast_speed_in  = csr_wdata[11:0];
            kats_pkg::CSR_MAX_ACCEL:   max_accel_in   = csr_wdata[18:0];
            kats_pkg::CSR_IDLE_TMO:    idle_tmo_in    = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Wrap-corrected angle delta and dead zone
   always_comb begin
      d_raw = $signed(DW'(in_angle_ff)) - $signed(DW'(last_angle_ff));
      if (d_raw > HALF_ANG) begin
         d_wrap = d_raw - FULL_ANG;
      end else if (d_raw < -HALF_ANG) begin
         d_wrap = d_raw + FULL_ANG;
      end else begin
         d_wrap = d_raw;
      end
      d_abs  = d_wrap[DW-1] ? -d_wrap : d_wrap;
      d_dead = d_abs <= $signed(DW'(dead_zone_ff));
   end

   // Exponential average: (delta * one + 3 * old) / 4, floored
   always_comb begin
      filt_d   = FW'(delta_ff) <<< FB;
      filt_s   = FW'(smooth_ff);
      filt_sum = filt_d + filt_s + (filt_s <<< 1);
   end

   // Mode machine decisions
   always_comb begin
      since_ms   = in_now_ff - last_motion_ff;
      timed_out  = since_ms > 32'(idle_tmo_ff);
      moving     = mag_ff >= MW'(stop_thresh_ff);
      mode_nx    = mode_ff;
      mode_touch = 1'b0;
      unique case (mode_ff)
         kats_pkg::MODE_ACTIVE: begin
            if (moving) begin
               mode_touch = 1'b1;
            end else if (timed_out) begin
               mode_nx = kats_pkg::MODE_IDLE;
            end
         end
         kats_pkg::MODE_IDLE: begin
            if (moving) begin
               mode_nx    = kats_pkg::MODE_ACTIVE;
               mode_touch = 1'b1;
            end
         end
         default: begin
            mode_nx    = kats_pkg::MODE_IDLE;
            mode_touch = 1'b1;
         end
      endcase
   end

   // Accumulator arithmetic around the shared multiplier
   always_comb begin
      cps_wide = $signed(PW'(base_cps_ff) << FB) + mul_prod;
      acc_sum  = SUMW'($signed(mul_prod[PW-1:FB])) + SUMW'(accum_ff);
      acc_fits = (&acc_sum[SUMW-1:31]) | ~(|acc_sum[SUMW-1:31]);
      acc_abs  = acc_ff[31] ? 32'(-acc_ff) : 32'(acc_ff);
      left32   = rem_ff[31:0];
      decay_m  = mul_prod[MW+kats_pkg::DECAY_SHIFT-1:kats_pkg::DECAY_SHIFT];
      out_load = ~rsp_valid_ff | rsp_ready;
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      mode_in        = mode_ff;
      last_angle_in  = last_angle_ff;
      last_valid_in  = last_valid_ff;
      smooth_in      = smooth_ff;
      accum_in       = accum_ff;
      last_motion_in = last_motion_ff;
      in_conn_in     = in_conn_ff;
      in_angle_in    = in_angle_ff;
      in_now_in      = in_now_ff;
      delta_in       = delta_ff;
      mag_in         = mag_ff;
      t_in           = t_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      fast_in        = fast_ff;
      accel_in       = accel_ff;
      cps_in         = cps_ff;
      acc_in         = acc_ff;
      acc_neg_in     = acc_neg_ff;
      nq_in          = nq_ff;
      res_steps_in   = res_steps_ff;
      res_poll_in    = res_poll_ff;
      rsp_steps_in   = rsp_steps_ff;
      rsp_mode_in    = rsp_mode_ff;
      rsp_poll_in    = rsp_poll_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      mul_a          = '0;
      mul_b          = '0;

      unique case (state_ff)
         // Take a new sample
         ST_IDLE: begin
            if (req_valid) begin
               in_conn_in  = req_connected;
               in_angle_in = req_angle;
               in_now_in   = req_now_ms;
               state_in    = ST_DELTA;
            end
         end
         // Drop the link, or form the delta
         ST_DELTA: begin
            if (!in_conn_ff) begin
               if (mode_ff != kats_pkg::MODE_ADV) begin
                  mode_in   = kats_pkg::MODE_ADV;
                  accum_in  = '0;
                  smooth_in = '0;
               end
               res_steps_in = '0;
               res_poll_in  = kats_pkg::POLL_ADV;
               state_in     = ST_OUT;
            end else begin
               delta_in      = (!last_valid_ff || d_dead) ? '0 : d_wrap[ANGLE_BITS:0];
               last_angle_in = in_angle_ff;
               last_valid_in = 1'b1;
               state_in      = ST_FILT;
            end
         end
         ST_FILT: begin
            smooth_in = filt_sum[SW+1:2];
            state_in  = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = smooth_ff[SW-1] ? MW'(-smooth_ff) : MW'(smooth_ff);
            state_in = ST_MODE;
         end
         // Advance the mode machine and pick the path
         ST_MODE: begin
            mode_in = mode_nx;
            if (mode_touch) begin
               last_motion_in = in_now_ff;
            end
            if (mode_nx == kats_pkg::MODE_ACTIVE) begin
               rem_in   = DVW'(mag_ff);
               dvs_in   = DVW'(fast_speed_ff) << FB;
               state_in = ST_TSAT;
            end else begin
               state_in = ST_DECAY;
            end
         end
         // Speed at or above full: t saturates at one
         ST_TSAT: begin
            if (div_res.ge) begin
               t_in     = kats_pkg::T_ONE;
               fast_in  = div_res.diff != '0;
               state_in = ST_MULA;
            end else begin
               t_in     = '0;
               fast_in  = 1'b0;
               dvs_in   = dvs_ff >> 1;
               cnt_in   = CW'(FB - 1);
               state_in = ST_TDIV;
            end
         end
         // One quotient bit of speed / fast_speed per cycle
         ST_TDIV: begin
            t_in   = {t_ff[TW-2:0], div_res.ge};
            dvs_in = dvs_ff >> 1;
            if (div_res.ge) begin
               rem_in = div_res.diff;
            end
            if (cnt_ff == '0) begin
               state_in = ST_MULA;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MULA: begin
            mul_a    = SW'(t_ff);
            mul_b    = BW'(max_accel_ff) - BW'(kats_pkg::T_ONE);
            state_in = ST_MULC;
         end
         ST_MULC: begin
            mul_a    = SW'(t_ff);
            mul_b    = BW'(fast_cps_ff) - BW'(base_cps_ff);
            accel_in = BW'(kats_pkg::T_ONE) + mul_prod[FB+BW-1:FB];
            state_in = ST_MULI;
         end
         ST_MULI: begin
            mul_a    = smooth_ff;
            mul_b    = accel_ff;
            cps_in   = (cps_wide < $signed(PW'(1))) ? 32'd1 : cps_wide[31:0];
            state_in = ST_ACC;
         end
         // Add the scaled delta, saturating to 32 bits
         ST_ACC: begin
            if (acc_fits) begin
               acc_in = acc_sum[31:0];
            end else if (acc_sum[SUMW-1]) begin
               acc_in = 32'sh8000_0000;
            end else begin
               acc_in = 32'sh7FFF_FFFF;
            end
            state_in = ST_ABS;
         end
         ST_ABS: begin
            acc_neg_in = acc_ff[31];
            rem_in     = DVW'(acc_abs);
            dvs_in     = DVW'(cps_ff) << (NQW - 1);
            nq_in      = '0;
            cnt_in     = CW'(NQW - 1);
            state_in   = ST_NDIV;
         end
         // Step count: five quotient bits, overflow settles at the cap
         ST_NDIV: begin
            nq_in  = {nq_ff[NQW-2:0], div_res.ge};
            dvs_in = dvs_ff >> 1;
            if (div_res.ge) begin
               rem_in = div_res.diff;
            end
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FIN: begin
            accum_in     = acc_neg_ff ? -$signed(left32) : $signed(left32);
            res_steps_in = acc_neg_ff ? $signed({1'b0, nq_ff}) : -$signed({1'b0, nq_ff});
            res_poll_in  = fast_ff ? kats_pkg::POLL_FAST : kats_pkg::POLL_SLOW;
            state_in     = ST_OUT;
         end
         // Idle decay by 0.85, sign kept
         ST_DECAY: begin
            mul_a    = SW'(mag_ff);
            mul_b    = BW'(kats_pkg::DECAY_MUL);
            state_in = ST_DECAYW;
         end
         ST_DECAYW: begin
            smooth_in    = smooth_ff[SW-1] ? -$signed(SW'(decay_m)) : $signed(SW'(decay_m));
            res_steps_in = '0;
            res_poll_in  = kats_pkg::POLL_IDLE;
            state_in     = ST_OUT;
         end
         // Hold until the output register is free
         ST_OUT: begin
            if (out_load) begin
               rsp_steps_in = res_steps_ff;
               rsp_mode_in  = mode_ff;
               rsp_poll_in  = res_poll_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control, mode and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         mode_ff        <= kats_pkg::MODE_ADV;
         last_angle_ff  <= '0;
         last_valid_ff  <= 1'b0;
         smooth_ff      <= '0;
         accum_ff       <= '0;
         last_motion_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         dead_zone_ff   <= kats_pkg::RST_DEAD_ZONE;
         stop_thresh_ff <= kats_pkg::RST_STOP_THRESH;
         base_cps_ff    <= kats_pkg::RST_BASE_CPS;
         fast_cps_ff    <= kats_pkg::RST_FAST_CPS;
         fast_speed_ff  <= kats_pkg::RST_FAST_SPEED;
         max_accel_ff   <= kats_pkg::RST_MAX_ACCEL;
         idle_tmo_ff    <= kats_pkg::RST_IDLE_TMO;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         mode_ff        <= mode_in;
         last_angle_ff  <= last_angle_in;
         last_valid_ff  <= last_valid_in;
         smooth_ff      <= smooth_in;
         accum_ff       <= accum_in;
         last_motion_ff <= last_motion_in;
         rsp_valid_ff   <= rsp_valid_in;
         dead_zone_ff   <= dead_zone_in;
         stop_thresh_ff <= stop_thresh_in;
         base_cps_ff    <= base_cps_in;
         fast_cps_ff    <= fast_cps_in;
         fast_speed_ff  <= fast_speed_in;
         max_accel_ff   <= max_accel_in;
         idle_tmo_ff    <= idle_tmo_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      in_conn_ff   <= in_conn_in;
      in_angle_ff  <= in_angle_in;
      in_now_ff    <= in_now_in;
      delta_ff     <= delta_in;
      mag_ff       <= mag_in;
      t_ff         <= t_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      fast_ff      <= fast_in;
      accel_ff     <= accel_in;
      cps_ff       <= cps_in;
      acc_ff       <= acc_in;
      acc_neg_ff   <= acc_neg_in;
      nq_ff        <= nq_in;
      res_steps_ff <= res_steps_in;
      res_poll_ff  <= res_poll_in;
      rsp_steps_ff <= rsp_steps_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_poll_ff  <= rsp_poll_in;
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wheel_steps   = rsp_steps_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_poll_delay_ms = rsp_poll_ff;

   // Checks
   `KATS_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_DELTA)
   `KATS_ASSERT_IMPL(a_t_bounded, state_ff == ST_MULA, t_ff <= kats_pkg::T_ONE)
   `KATS_ASSERT_IMPL(a_steps_capped, rsp_valid, rsp_wheel_steps != $signed(6'b100000))
   `KATS_ASSERT_IMPL(a_quiet_modes, rsp_valid && rsp_mode != kats_pkg::MODE_ACTIVE, rsp_wheel_steps == 6'sd0)
   `KATS_ASSERT_IMPL(a_adv_poll, rsp_valid && rsp_mode == kats_pkg::MODE_ADV, rsp_poll_delay_ms == kats_pkg::POLL_ADV)

endmodule

`default_nettype wire

### hdl/kats_mul.sv
// Registered signed multiplier shared by the sequencer
`default_nettype none

module kats_mul #(
   parameter int A_W = 29,
   parameter int B_W = 20
) (
   input  logic                       clock,
   input  logic signed [A_W-1:0]      mul_a,
   input  logic signed [B_W-1:0]      mul_b,
   output logic signed [A_W+B_W-1:0]  mul_prod
);

   localparam int P_W = A_W + B_W;

   logic signed [P_W-1:0] prod_ff;
   logic signed [P_W-1:0] prod_in;

   // Form the full signed product
   always_comb begin
      prod_in = P_W'(mul_a) * P_W'(mul_b);
   end

   // Register the product for the next sequencer step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

### hdl/kats_div_step.sv
// One restoring-division step: compare and subtract
`default_nettype none

module kats_div_step (
   input  logic [kats_pkg::DIV_W-1:0] step_rem,
   input  logic [kats_pkg::DIV_W-1:0] step_dvs,
   output kats_pkg::div_res_type      step_res
);

   logic [kats_pkg::DIV_W:0] sub_full;

   // Single subtractor; no borrow means remainder covers the divisor
   always_comb begin
      sub_full      = {1'b0, step_rem} - {1'b0, step_dvs};
      step_res.ge   = ~sub_full[kats_pkg::DIV_W];
      step_res.diff = sub_full[kats_pkg::DIV_W-1:0];
   end

endmodule

`default_nettype wire
